// ===== rtl/lxpf_pkg.sv =====
// Shared types and constants of the length and XOR checksum packet framer.
package lxpf_pkg;

  localparam int unsigned BYTE_W    = 8;
  localparam int unsigned CFG_IDX_W = 8;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_START_MARKER   = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_COMMAND_CODE   = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_END_MARKER     = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_PAYLOAD_LENGTH = CFG_IDX_W'(3);

  // One accepted payload byte, fully framed, waiting to be sent.
  typedef struct packed {
    logic [BYTE_W-1:0] data;      // the payload byte itself
    logic [BYTE_W-1:0] checksum;  // running XOR after this byte
    logic [BYTE_W-1:0] length;    // effective length, sent as the length byte
    logic              header;    // first byte of a packet: send the header first
    logic              finish;    // last byte of a packet: send the trailer after it
  } item_t;

endpackage

// ===== rtl/lxpf_if.sv =====
// Valid/ready stream interfaces for payload bytes and framed packet bytes.
interface lxpf_in_if;
  import lxpf_pkg::*;

  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] payload_byte;

  modport source (output valid, output payload_byte, input ready);
  modport sink (input valid, input payload_byte, output ready);
endinterface

interface lxpf_out_if;
  import lxpf_pkg::*;

  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] out_byte;
  logic              run_last;
  logic              packet_end;

  modport source (output valid, output out_byte, output run_last, output packet_end,
                  input ready);
  modport sink (input valid, input out_byte, input run_last, input packet_end,
                output ready);
endinterface

// ===== rtl/lxpf_emit.sv =====
// Output sequencer: holds one framed item and sends its bytes one per request.
module lxpf_emit
  import lxpf_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              item_valid_i,
  output logic              item_ready_o,
  input  item_t             item_i,
  input  logic [BYTE_W-1:0] start_marker_i,
  input  logic [BYTE_W-1:0] command_code_i,
  input  logic [BYTE_W-1:0] end_marker_i,
  lxpf_out_if.source        pkt_o
);

  typedef enum logic [2:0] {
    S_START,
    S_CMD,
    S_LEN,
    S_DATA,
    S_XOR,
    S_END
  } step_e;

  logic  busy_q;
  step_e step_q;
  step_e step_next;
  item_t item_q;
  logic  take;
  logic  last;
  logic  done;
  logic  load;

  // The data byte closes the run unless a trailer follows; the end marker always does.
  assign last = (step_q == S_END) || ((step_q == S_DATA) && !item_q.finish);
  assign take = busy_q && pkt_o.ready;
  assign done = take && last;
  assign item_ready_o = !busy_q || done;
  assign load = item_valid_i && item_ready_o;

  always_comb begin
    unique case (step_q)
      S_START: step_next = S_CMD;
      S_CMD:   step_next = S_LEN;
      S_LEN:   step_next = S_DATA;
      S_DATA:  step_next = S_XOR;
      S_XOR:   step_next = S_END;
      S_END:   step_next = S_START;
      default: step_next = S_START;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      step_q <= S_START;
    end else if (load) begin
      busy_q <= 1'b1;
      step_q <= item_i.header ? S_START : S_DATA;
    end else if (done) begin
      busy_q <= 1'b0;
    end else if (take) begin
      step_q <= step_next;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      item_q <= item_i;
    end
  end

  always_comb begin
    unique case (step_q)
      S_START: pkt_o.out_byte = start_marker_i;
      S_CMD:   pkt_o.out_byte = command_code_i;
      S_LEN:   pkt_o.out_byte = item_q.length;
      S_DATA:  pkt_o.out_byte = item_q.data;
      S_XOR:   pkt_o.out_byte = item_q.checksum;
      S_END:   pkt_o.out_byte = end_marker_i;
      default: pkt_o.out_byte = item_q.data;
    endcase
  end

  assign pkt_o.valid      = busy_q;
  assign pkt_o.run_last   = last;
  assign pkt_o.packet_end = (step_q == S_END);

endmodule

// ===== rtl/length_xor_packet_framer.sv =====
// Top level of the length and XOR checksum packet framer.
//
// Payload bytes arrive one per request on pld_i; a configured number of them
// forms one packet. Framed bytes leave one per request on pkt_o. The first
// payload byte of a packet yields start marker, command code, length byte and
// the byte itself; middle bytes yield only themselves; the last byte yields
// itself, the XOR checksum and the end marker. run_last marks the final byte
// caused by one payload byte, packet_end marks the end marker.
// Registers are written through cfg_we_i, cfg_idx_i and cfg_wdata_i: index 0
// start marker, 1 command code, 2 end marker, 3 payload length (0 acts as 1,
// above MAX_PAYLOAD acts as MAX_PAYLOAD). The user is to write them only while
// the block is idle; the block does not enforce it. A payload byte's first
// framed byte is offered in the cycle after acceptance. It causes from one
// framed byte for a middle byte to six for a one-byte packet; middle bytes
// stream at one per cycle while the receiver is ready: the next byte is
// accepted in the same cycle the last framed byte is taken. The single item
// holding register in the output sequencer sets this rate. Reset clears the
// registers to their defaults, starts a fresh packet and empties the output.
// When the receiver stalls, the offered byte holds and pld_i.ready stays low
// until the final byte of the held item is taken.
module length_xor_packet_framer
  import lxpf_pkg::*;
#(
  parameter int unsigned MAX_PAYLOAD = 250
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [BYTE_W-1:0]    cfg_wdata_i,
  lxpf_in_if.sink              pld_i,
  lxpf_out_if.source           pkt_o
);

  // Position counter only needs to reach MAX_PAYLOAD - 1.
  localparam int unsigned POS_W = $clog2(MAX_PAYLOAD + 1);

  logic [BYTE_W-1:0] start_marker_q;
  logic [BYTE_W-1:0] command_code_q;
  logic [BYTE_W-1:0] end_marker_q;
  logic [BYTE_W-1:0] payload_length_q;

  logic [POS_W-1:0]  pos_q;
  logic [BYTE_W-1:0] xor_q;

  logic [BYTE_W-1:0] eff_len;
  logic [BYTE_W:0]   taken;
  logic [BYTE_W-1:0] xor_seed;
  logic              accept;
  logic              item_ready;
  item_t             item;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_marker_q   <= '0;
      command_code_q   <= '0;
      end_marker_q     <= '0;
      payload_length_q <= BYTE_W'(1);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_START_MARKER:   start_marker_q   <= cfg_wdata_i;
        REG_COMMAND_CODE:   command_code_q   <= cfg_wdata_i;
        REG_END_MARKER:     end_marker_q     <= cfg_wdata_i;
        REG_PAYLOAD_LENGTH: payload_length_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Clamp the programmed length into the supported range.
  always_comb begin
    if (payload_length_q == '0) begin
      eff_len = BYTE_W'(1);
    end else if (payload_length_q > BYTE_W'(MAX_PAYLOAD)) begin
      eff_len = BYTE_W'(MAX_PAYLOAD);
    end else begin
      eff_len = payload_length_q;
    end
  end

  // Frame the incoming byte in one pass: header flag, checksum and packet end.
  assign taken    = (BYTE_W + 1)'(pos_q) + (BYTE_W + 1)'(1);
  assign xor_seed = (pos_q == '0) ? (command_code_q ^ eff_len) : xor_q;

  assign item.data     = pld_i.payload_byte;
  assign item.checksum = xor_seed ^ pld_i.payload_byte;
  assign item.length   = eff_len;
  assign item.header   = (pos_q == '0);
  assign item.finish   = (taken >= {1'b0, eff_len});

  assign pld_i.ready = item_ready;
  assign accept      = pld_i.valid && item_ready;

  // Packet position and running checksum advance with every accepted byte.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
      xor_q <= '0;
    end else if (accept) begin
      if (item.finish) begin
        pos_q <= '0;
        xor_q <= '0;
      end else begin
        pos_q <= taken[POS_W-1:0];
        xor_q <= item.checksum;
      end
    end
  end

  lxpf_emit u_emit (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .item_valid_i   (pld_i.valid),
    .item_ready_o   (item_ready),
    .item_i         (item),
    .start_marker_i (start_marker_q),
    .command_code_i (command_code_q),
    .end_marker_i   (end_marker_q),
    .pkt_o          (pkt_o)
  );

endmodule

// ===== test/testbench.sv =====
// Self-checking testbench for the length and XOR checksum packet framer.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import lxpf_pkg::*;

  localparam int unsigned MAX_PAYLOAD = 250;

  // Configuration indexes the block does not decode, so writes there must
  // leave every register alone.
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_LOW      = 8'd4;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_HIGH     = 8'd255;

  localparam int unsigned IDLE_MAX     = 18;   // longest wait either side draws
  localparam int unsigned HOLD_CYCLES  = 300;  // long receiver hold-off
  localparam int unsigned RANDOM_ITEMS = 100;  // payload bytes in the random part
  localparam int unsigned TAIL_CYCLES  = 10;   // settle time once nothing is due
  localparam int unsigned HOLD_ROUND   = 4;    // random round that gets the hold-off

  // One framed byte as it should leave the block.
  typedef struct packed {
    logic [BYTE_W-1:0] out_byte;
    logic              run_last;
    logic              packet_end;
  } frame_byte_t;

  logic                 clk_i       = 1'b0;
  logic                 rst_ni      = 1'b0;
  logic                 cfg_we_i    = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i   = '0;
  logic [BYTE_W-1:0]    cfg_wdata_i = '0;

  lxpf_in_if  pld ();
  lxpf_out_if pkt ();

  length_xor_packet_framer #(
    .MAX_PAYLOAD(MAX_PAYLOAD)
  ) uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i),
    .pld_i      (pld),
    .pkt_o      (pkt)
  );

  // 20 ns clock. Inputs move on the falling edge, outputs are sampled on the
  // rising edge, so nothing depends on scheduling order within a time step.
  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Shadow copy of the registers and the framing state. The registers are
  // only written while the block is idle, so updating the shadow copy at the
  // moment the write is driven is safe.
  logic [BYTE_W-1:0] cfg_start  = 8'h00;
  logic [BYTE_W-1:0] cfg_cmd    = 8'h00;
  logic [BYTE_W-1:0] cfg_end    = 8'h00;
  logic [BYTE_W-1:0] cfg_length = 8'h01;
  logic [BYTE_W-1:0] frame_pos  = 8'h00;  // payload bytes taken in this packet
  logic [BYTE_W-1:0] frame_xor  = 8'h00;  // checksum folded so far

  frame_byte_t       frame_due_q[$];      // framed bytes still to come out
  logic [BYTE_W-1:0] payload_q[$];        // payload bytes waiting to be offered

  // Handshake bookkeeping. Each counter has exactly one writing process.
  int unsigned pushed_cnt      = 0;
  int unsigned pld_taken_cnt   = 0;
  int unsigned pld_offered_cnt = 0;
  int unsigned pkt_taken_cnt   = 0;
  int unsigned pkt_seen_cnt    = 0;
  int unsigned mismatch_cnt    = 0;
  int unsigned packets_framed  = 0;
  int unsigned reg_writes      = 0;

  logic        pld_offering  = 1'b0;
  int unsigned pld_gap       = 0;
  int unsigned pld_gap_max   = 3;
  int unsigned pkt_stall     = 0;
  int unsigned pkt_stall_max = 3;
  logic        hold_armed    = 1'b0;
  int unsigned hold_count    = 0;
  logic        pkt_hold      = 1'b0;

  // A zero length acts as one and anything past the maximum is clamped.
  function automatic int unsigned clamped_length(logic [BYTE_W-1:0] raw);
    if (raw == '0) return 1;
    if (32'(raw) > MAX_PAYLOAD) return MAX_PAYLOAD;
    return 32'(raw);
  endfunction

  function automatic void queue_frame_byte(logic [BYTE_W-1:0] value, logic last_of_run,
                                           logic end_of_packet);
    frame_due_q.push_back(frame_byte_t'{value, last_of_run, end_of_packet});
  endfunction

  // Works out the framed bytes one accepted payload byte causes. Every byte
  // uses the register values at the time it is produced; the packet closes
  // once the taken count reaches the current effective length, which also
  // covers a length lowered below the count already taken.
  task automatic frame_payload_byte(input logic [BYTE_W-1:0] data);
    int unsigned len;
    logic        closes;
    len = clamped_length(cfg_length);
    if (frame_pos == '0) begin
      queue_frame_byte(cfg_start, 1'b0, 1'b0);
      queue_frame_byte(cfg_cmd, 1'b0, 1'b0);
      queue_frame_byte(len[BYTE_W-1:0], 1'b0, 1'b0);
      frame_xor = cfg_cmd ^ len[BYTE_W-1:0];
    end
    frame_xor = frame_xor ^ data;
    closes = (32'(frame_pos) + 32'd1) >= len;
    queue_frame_byte(data, !closes, 1'b0);
    if (closes) begin
      queue_frame_byte(frame_xor, 1'b0, 1'b0);
      queue_frame_byte(cfg_end, 1'b1, 1'b1);
      frame_pos = '0;
      frame_xor = '0;
      packets_framed++;
    end else begin
      frame_pos = frame_pos + 8'd1;
    end
  endtask

  // Rising edge: check the framed byte taken in this cycle against the oldest
  // one due, then predict for a payload byte taken in this cycle. Checking
  // first keeps the order fixed when both handshakes complete together.
  always @(posedge clk_i) begin : frame_checker
    frame_byte_t due;
    if (rst_ni) begin
      if (pkt.valid && pkt.ready) begin
        pkt_taken_cnt++;
        if (frame_due_q.size() == 0) begin
          $error("out_byte: expected nothing, got %02h", pkt.out_byte);
          mismatch_cnt++;
        end else begin
          due = frame_due_q.pop_front();
          if (pkt.out_byte !== due.out_byte) begin
            $error("out_byte: expected %02h, got %02h", due.out_byte, pkt.out_byte);
            mismatch_cnt++;
          end
          if (pkt.run_last !== due.run_last) begin
            $error("run_last: expected %0b, got %0b", due.run_last, pkt.run_last);
            mismatch_cnt++;
          end
          if (pkt.packet_end !== due.packet_end) begin
            $error("packet_end: expected %0b, got %0b", due.packet_end, pkt.packet_end);
            mismatch_cnt++;
          end
        end
      end
      if (pld.valid && pld.ready) begin
        pld_taken_cnt++;
        frame_payload_byte(pld.payload_byte);
      end
    end
  end

  // Payload sender. After each accepted request it draws an idle gap; a gap
  // of zero keeps valid high straight into the next request.
  always @(negedge clk_i) begin : payload_sender
    if (!rst_ni) begin
      pld.valid        <= 1'b0;
      pld.payload_byte <= '0;
    end else begin
      if (pld_offering && pld_taken_cnt == pld_offered_cnt) begin
        pld_offering = 1'b0;
        pld_gap = $urandom_range(0, pld_gap_max);
      end
      if (!pld_offering) begin
        if (pld_gap > 0) begin
          pld_gap--;
        end else if (payload_q.size() != 0) begin
          pld.payload_byte <= payload_q.pop_front();
          pld_offering = 1'b1;
          pld_offered_cnt++;
        end
      end
      pld.valid <= pld_offering;
    end
  end

  // Packet receiver. It stalls for a drawn number of cycles before each
  // framed byte and also while the long hold-off is active.
  always @(negedge clk_i) begin : packet_receiver
    if (!rst_ni) begin
      pkt.ready <= 1'b0;
    end else begin
      if (pkt_taken_cnt != pkt_seen_cnt) begin
        pkt_seen_cnt = pkt_taken_cnt;
        pkt_stall = $urandom_range(0, pkt_stall_max);
      end
      if (pkt_stall > 0) begin
        pkt_stall--;
        pkt.ready <= 1'b0;
      end else begin
        pkt.ready <= !pkt_hold;
      end
    end
  end

  // Once armed, the receiver refuses every framed byte for a long stretch
  // while the sender keeps offering, so the block backs up and stalls pld_i.
  always @(negedge clk_i) begin : receiver_hold
    if (hold_armed && hold_count < HOLD_CYCLES) begin
      hold_count++;
      pkt_hold <= 1'b1;
    end else begin
      pkt_hold <= 1'b0;
    end
  end

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [BYTE_W-1:0] value);
    @(negedge clk_i);
    cfg_we_i    = 1'b1;
    cfg_idx_i   = idx;
    cfg_wdata_i = value;
    reg_writes++;
    case (idx)
      REG_START_MARKER:   cfg_start  = value;
      REG_COMMAND_CODE:   cfg_cmd    = value;
      REG_END_MARKER:     cfg_end    = value;
      REG_PAYLOAD_LENGTH: cfg_length = value;
      default: ;
    endcase
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  task automatic offer_payload(input logic [BYTE_W-1:0] data);
    payload_q.push_back(data);
    pushed_cnt++;
  endtask

  // Returns once every offered byte has been taken and every framed byte
  // has come out, plus a short settle time.
  task automatic wait_idle();
    do @(negedge clk_i);
    while (pld_taken_cnt != pushed_cnt || frame_due_q.size() != 0);
    repeat (TAIL_CYCLES) @(negedge clk_i);
  endtask

  // Random byte with the two extremes showing up more often than chance.
  function automatic logic [BYTE_W-1:0] random_byte();
    case ($urandom_range(0, 7))
      0:       return 8'h00;
      1:       return 8'hFF;
      default: return BYTE_W'($urandom);
    endcase
  endfunction

  // Mostly short packets; now and then zero or a length at or past the limit.
  function automatic logic [BYTE_W-1:0] random_length();
    case ($urandom_range(0, 15))
      0:       return 8'h00;
      1:       return BYTE_W'($urandom_range(MAX_PAYLOAD, 255));
      default: return BYTE_W'($urandom_range(1, 12));
    endcase
  endfunction

  // Idle bound for one round: no idling at all, light idling or the full range.
  function automatic int unsigned idle_limit();
    case ($urandom_range(0, 3))
      0:       return 0;
      1:       return 3;
      default: return IDLE_MAX;
    endcase
  endfunction

  initial begin : stimulus
    int unsigned count;
    int unsigned random_sent;
    int unsigned round;
    random_sent = 0;
    round       = 0;
    repeat (7) @(negedge clk_i);
    rst_ni = 1'b1;

    // Reset values: zero markers and command, length one.
    offer_payload(8'h00);
    wait_idle();

    // All-ones registers, a zero length acting as one, and writes to indexes
    // the block does not decode.
    write_reg(REG_START_MARKER, 8'hFF);
    write_reg(REG_COMMAND_CODE, 8'hFF);
    write_reg(REG_END_MARKER, 8'hFF);
    write_reg(REG_PAYLOAD_LENGTH, 8'h00);
    write_reg(REG_SPARE_LOW, 8'h5A);
    write_reg(REG_SPARE_HIGH, 8'hA5);
    offer_payload(8'hFF);
    wait_idle();

    // Two plain three-byte packets back to back.
    write_reg(REG_START_MARKER, 8'hA5);
    write_reg(REG_COMMAND_CODE, 8'h3C);
    write_reg(REG_END_MARKER, 8'h5A);
    write_reg(REG_PAYLOAD_LENGTH, 8'h03);
    offer_payload(8'h00);
    offer_payload(8'hFF);
    offer_payload(8'h81);
    offer_payload(8'h7E);
    offer_payload(8'h18);
    offer_payload(8'h24);
    wait_idle();

    // Registers changed inside a packet: the new command must not touch the
    // checksum, the new end marker and shorter length apply at once.
    write_reg(REG_PAYLOAD_LENGTH, 8'h06);
    offer_payload(8'h11);
    offer_payload(8'h22);
    wait_idle();
    write_reg(REG_COMMAND_CODE, 8'h99);
    write_reg(REG_END_MARKER, 8'h42);
    write_reg(REG_PAYLOAD_LENGTH, 8'h03);
    offer_payload(8'h33);
    wait_idle();

    // Length lowered below the count already taken: the next byte closes.
    write_reg(REG_PAYLOAD_LENGTH, 8'h04);
    offer_payload(8'h44);
    offer_payload(8'h55);
    wait_idle();
    write_reg(REG_PAYLOAD_LENGTH, 8'h01);
    offer_payload(8'h66);
    wait_idle();

    // Length raised inside a packet: the packet runs on to the new length.
    write_reg(REG_PAYLOAD_LENGTH, 8'h02);
    offer_payload(8'h77);
    wait_idle();
    write_reg(REG_PAYLOAD_LENGTH, 8'h04);
    offer_payload(8'h88);
    offer_payload(8'h99);
    offer_payload(8'hAA);
    wait_idle();

    // Length past the limit is sent as the limit; cut short with a zero length.
    write_reg(REG_PAYLOAD_LENGTH, 8'(MAX_PAYLOAD + 1));
    offer_payload(8'hC3);
    offer_payload(8'h3C);
    wait_idle();
    write_reg(REG_PAYLOAD_LENGTH, 8'h00);
    offer_payload(8'h5A);
    wait_idle();

    // Length at the limit, cut short after one byte.
    write_reg(REG_PAYLOAD_LENGTH, 8'(MAX_PAYLOAD));
    offer_payload(8'h01);
    wait_idle();
    write_reg(REG_PAYLOAD_LENGTH, 8'h01);
    offer_payload(8'h80);
    wait_idle();

    // One full packet with the length register at its top value, which must
    // close after exactly the clamped number of bytes.
    write_reg(REG_PAYLOAD_LENGTH, 8'hFF);
    repeat (MAX_PAYLOAD) offer_payload(random_byte());
    wait_idle();

    // Random rounds: fresh register values now and then (often in the middle
    // of a packet), a new idling pattern per round and a burst of bytes.
    while (random_sent < RANDOM_ITEMS) begin
      wait_idle();
      if ($urandom_range(0, 1) != 0) write_reg(REG_START_MARKER, random_byte());
      if ($urandom_range(0, 1) != 0) write_reg(REG_COMMAND_CODE, random_byte());
      if ($urandom_range(0, 1) != 0) write_reg(REG_END_MARKER, random_byte());
      if ($urandom_range(0, 1) != 0) write_reg(REG_PAYLOAD_LENGTH, random_length());
      if ($urandom_range(0, 7) == 0) begin
        write_reg(CFG_IDX_W'($urandom_range(REG_SPARE_LOW, REG_SPARE_HIGH)), random_byte());
      end
      pld_gap_max   = idle_limit();
      pkt_stall_max = idle_limit();
      count = $urandom_range(1, 24);
      if (round == HOLD_ROUND) begin
        // The sender runs flat out into a receiver that has stopped.
        hold_armed  = 1'b1;
        pld_gap_max = 0;
        count       = 24;
      end
      repeat (count) offer_payload(random_byte());
      random_sent += count;
      round++;
    end
    wait_idle();

    $display("Framed %0d payload bytes into %0d closed packets; %0d packet bytes compared.",
             pld_taken_cnt, packets_framed, pkt_taken_cnt);
    $display("Made %0d register writes over %0d random rounds, with one long receiver hold-off.",
             reg_writes, round);
    if (mismatch_cnt == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // A hung handshake ends the run here.
  initial begin : watchdog
    #20ms;
    $display("Regression FAIL");
    $finish;
  end

endmodule

// ===== length_xor_packet_framer.f =====
rtl/lxpf_pkg.sv
rtl/lxpf_if.sv
rtl/lxpf_emit.sv
rtl/length_xor_packet_framer.sv
test/testbench.sv
